### rtl/evpn_prefix_route_parser_unit_assert.svh
// Assertion macros shared by the route parser RTL
`ifndef EVPN_PREFIX_ROUTE_PARSER_UNIT_ASSERT_SVH
`define EVPN_PREFIX_ROUTE_PARSER_UNIT_ASSERT_SVH

// Check cons in the same cycle as ante
`define EPR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante
`define EPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/epr_pkg.sv
// Types, codes and constants of the EVPN prefix route parser
package epr_pkg;

  localparam int CFG_AW = 1;
  localparam int CFG_DW = 32;
  localparam logic [CFG_AW-1:0] REG_PEER_EST = 1'd0;

  localparam logic [7:0] PREFIX_ROUTE_TYPE_DEF = 8'd5;

  localparam logic [7:0] MAX_PLEN   = 8'd128;
  localparam logic [7:0] V6_MIN_LEN = 8'd57;

  localparam logic [4:0] RD_BYTES    = 5'd8;
  localparam logic [4:0] ESI_BYTES   = 5'd10;
  localparam logic [4:0] TAG_BYTES   = 5'd4;
  localparam logic [4:0] LABEL_BYTES = 5'd3;
  localparam logic [4:0] ADDR_V6     = 5'd16;
  localparam logic [4:0] ADDR_V4     = 5'd4;

  typedef enum logic [2:0] {
    KIND_RD     = 3'd0,
    KIND_ESI_HI = 3'd1,
    KIND_ESI_LO = 3'd2,
    KIND_PFX_HI = 3'd3,
    KIND_PFX_LO = 3'd4,
    KIND_GW_HI  = 3'd5,
    KIND_GW_LO  = 3'd6,
    KIND_END    = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TRUNC    = 2'd1,
    ST_BAD_PLEN = 2'd2
  } status_t;

  typedef struct packed {
    logic          has_route;
    logic          has_end;
    status_t       status;
    logic          withdraw;
    logic          ipv6;
    logic [7:0]    plen;
    logic [31:0]   tag;
    logic [23:0]   label;
    logic [63:0]   rd;
    logic [15:0]   esi_hi;
    logic [63:0]   esi_lo;
    logic [127:0]  pfx;
    logic [127:0]  gw;
  } epr_rec_t;

endpackage

### rtl/epr_stream_if.sv
// Valid/ready channel interfaces for NLRI bytes and result words
interface epr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_nlri;
  logic       withdraw_flag;

  modport source (output valid, data_byte, end_of_nlri, withdraw_flag, input ready);
  modport sink   (input valid, data_byte, end_of_nlri, withdraw_flag, output ready);
endinterface

interface epr_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  word_kind;
  logic [63:0] word_value;
  logic        is_withdraw;
  logic        is_ipv6;
  logic [7:0]  prefix_length;
  logic [31:0] ethernet_tag;
  logic [23:0] mpls_label;
  logic        last_word;
  logic [1:0]  parse_status;

  modport source (output valid, word_kind, word_value, is_withdraw, is_ipv6,
                  prefix_length, ethernet_tag, mpls_label, last_word, parse_status,
                  input ready);
  modport sink   (input valid, word_kind, word_value, is_withdraw, is_ipv6,
                  prefix_length, ethernet_tag, mpls_label, last_word, parse_status,
                  output ready);
endinterface

### rtl/epr_cfg_regs.sv
// APB-style configuration register bank
module epr_cfg_regs
  import epr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready,
  output logic              peer_est
);

  logic peer_est_r;
  logic wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peer_est_r <= 1'b0;
    end else if (wr_en && cfg_paddr == REG_PEER_EST) begin
      peer_est_r <= cfg_pwdata[0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr == REG_PEER_EST) begin
      cfg_prdata = {{(CFG_DW-1){1'b0}}, peer_est_r};
    end
  end

  assign peer_est = peer_est_r;

endmodule

### rtl/epr_parser.sv
// Input register and byte-wise route record parser
module epr_parser
  import epr_pkg::*;
#(
  parameter logic [7:0] PREFIX_ROUTE_TYPE = PREFIX_ROUTE_TYPE_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     peer_est,
  epr_in_if.sink   in_if,
  input  logic     ser_free,
  output logic     rec_load,
  output epr_rec_t rec
);

  typedef enum logic [3:0] {
    PH_TYPE    = 4'd0,
    PH_LEN     = 4'd1,
    PH_SKIP    = 4'd2,
    PH_RD      = 4'd3,
    PH_ESI     = 4'd4,
    PH_TAG     = 4'd5,
    PH_PLEN    = 4'd6,
    PH_PREFIX  = 4'd7,
    PH_GW      = 4'd8,
    PH_LABEL   = 4'd9,
    PH_DISCARD = 4'd10
  } phase_t;

  logic          in_vld_r;
  logic [7:0]    byte_r;
  logic          end_r;
  logic          wd_r;

  phase_t        phase_r, phase_nxt, phase_mid;
  logic [4:0]    fbc_r, fbc_nxt, fbc_inc, addr_len;
  logic [7:0]    type_r, type_nxt;
  logic [7:0]    len_r, len_nxt;
  logic [63:0]   rd_r, rd_nxt;
  logic [79:0]   esi_r, esi_nxt;
  logic [31:0]   tag_r, tag_nxt;
  logic [7:0]    plen_r, plen_nxt;
  logic [127:0]  pfx_r, pfx_nxt;
  logic [127:0]  gw_r, gw_nxt;
  logic [23:0]   label_r, label_nxt;
  status_t       err_r, err_nxt, err_mid;
  logic          route_done;
  logic          ipv6;
  logic          gen;
  logic          consume;

  assign ipv6     = (len_r >= V6_MIN_LEN);
  assign addr_len = ipv6 ? ADDR_V6 : ADDR_V4;
  assign fbc_inc  = fbc_r + 5'd1;

  always_comb begin
    phase_nxt  = phase_r;
    fbc_nxt    = fbc_r;
    type_nxt   = type_r;
    len_nxt    = len_r;
    rd_nxt     = rd_r;
    esi_nxt    = esi_r;
    tag_nxt    = tag_r;
    plen_nxt   = plen_r;
    pfx_nxt    = pfx_r;
    gw_nxt     = gw_r;
    label_nxt  = label_r;
    err_nxt    = err_r;
    route_done = 1'b0;

    unique case (phase_r)
      PH_TYPE: begin
        fbc_nxt   = '0;
        rd_nxt    = '0;
        esi_nxt   = '0;
        tag_nxt   = '0;
        plen_nxt  = '0;
        pfx_nxt   = '0;
        gw_nxt    = '0;
        label_nxt = '0;
        type_nxt  = byte_r;
        phase_nxt = PH_LEN;
      end
      PH_LEN: begin
        len_nxt = byte_r;
        fbc_nxt = '0;
        if (type_r == PREFIX_ROUTE_TYPE) begin
          phase_nxt = PH_RD;
        end else begin
          phase_nxt = (byte_r == 8'd0) ? PH_TYPE : PH_SKIP;
        end
      end
      PH_SKIP: begin
        len_nxt = len_r - 8'd1;
        if (len_r == 8'd1) begin
          phase_nxt = PH_TYPE;
        end
      end
      PH_RD: begin
        rd_nxt  = {rd_r[55:0], byte_r};
        fbc_nxt = fbc_inc;
        if (fbc_inc >= RD_BYTES) begin
          fbc_nxt   = '0;
          phase_nxt = PH_ESI;
        end
      end
      PH_ESI: begin
        esi_nxt = {esi_r[71:0], byte_r};
        fbc_nxt = fbc_inc;
        if (fbc_inc >= ESI_BYTES) begin
          fbc_nxt   = '0;
          phase_nxt = PH_TAG;
        end
      end
      PH_TAG: begin
        tag_nxt = {tag_r[23:0], byte_r};
        fbc_nxt = fbc_inc;
        if (fbc_inc >= TAG_BYTES) begin
          fbc_nxt   = '0;
          phase_nxt = PH_PLEN;
        end
      end
      PH_PLEN: begin
        plen_nxt = byte_r;
        if (byte_r > MAX_PLEN) begin
          err_nxt   = ST_BAD_PLEN;
          phase_nxt = PH_DISCARD;
        end else begin
          phase_nxt = PH_PREFIX;
        end
      end
      PH_PREFIX: begin
        pfx_nxt = {pfx_r[119:0], byte_r};
        fbc_nxt = fbc_inc;
        if (fbc_inc >= addr_len) begin
          fbc_nxt   = '0;
          phase_nxt = PH_GW;
        end
      end
      PH_GW: begin
        gw_nxt  = {gw_r[119:0], byte_r};
        fbc_nxt = fbc_inc;
        if (fbc_inc >= addr_len) begin
          fbc_nxt   = '0;
          phase_nxt = PH_LABEL;
        end
      end
      PH_LABEL: begin
        label_nxt = {label_r[15:0], byte_r};
        fbc_nxt   = fbc_inc;
        if (fbc_inc >= LABEL_BYTES) begin
          fbc_nxt    = '0;
          route_done = 1'b1;
          phase_nxt  = PH_TYPE;
        end
      end
      default: begin
        phase_nxt = PH_DISCARD;
      end
    endcase

    phase_mid = phase_nxt;
    err_mid   = err_nxt;

    rec.has_route = route_done;
    rec.has_end   = end_r;
    rec.status    = (err_mid == ST_OK && phase_mid != PH_TYPE) ? ST_TRUNC : err_mid;
    rec.withdraw  = wd_r;
    rec.ipv6      = ipv6;
    rec.plen      = plen_nxt;
    rec.tag       = tag_nxt;
    rec.label     = label_nxt;
    rec.rd        = rd_nxt;
    rec.esi_hi    = esi_nxt[79:64];
    rec.esi_lo    = esi_nxt[63:0];
    rec.pfx       = pfx_nxt;
    rec.gw        = gw_nxt;

    if (end_r) begin
      phase_nxt = PH_TYPE;
      err_nxt   = ST_OK;
      type_nxt  = '0;
      len_nxt   = '0;
      fbc_nxt   = '0;
      rd_nxt    = '0;
      esi_nxt   = '0;
      tag_nxt   = '0;
      plen_nxt  = '0;
      pfx_nxt   = '0;
      gw_nxt    = '0;
      label_nxt = '0;
    end
  end

  assign gen         = peer_est && (route_done || end_r);
  assign consume     = in_vld_r && (!gen || ser_free);
  assign rec_load    = consume && gen;
  assign in_if.ready = !in_vld_r || consume;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      phase_r  <= PH_TYPE;
      fbc_r    <= '0;
      type_r   <= '0;
      len_r    <= '0;
      rd_r     <= '0;
      esi_r    <= '0;
      tag_r    <= '0;
      plen_r   <= '0;
      pfx_r    <= '0;
      gw_r     <= '0;
      label_r  <= '0;
      err_r    <= ST_OK;
    end else begin
      if (in_if.valid && in_if.ready) begin
        in_vld_r <= 1'b1;
      end else if (consume) begin
        in_vld_r <= 1'b0;
      end
      if (consume && peer_est) begin
        phase_r <= phase_nxt;
        fbc_r   <= fbc_nxt;
        type_r  <= type_nxt;
        len_r   <= len_nxt;
        rd_r    <= rd_nxt;
        esi_r   <= esi_nxt;
        tag_r   <= tag_nxt;
        plen_r  <= plen_nxt;
        pfx_r   <= pfx_nxt;
        gw_r    <= gw_nxt;
        label_r <= label_nxt;
        err_r   <= err_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      byte_r <= in_if.data_byte;
      end_r  <= in_if.end_of_nlri;
      wd_r   <= in_if.withdraw_flag;
    end
  end

endmodule

### rtl/epr_word_ser.sv
// Result register that sends a route record as a run of words
module epr_word_ser
  import epr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     rec_load,
  input  epr_rec_t rec,
  output logic     ser_free,
  epr_out_if.source out_if
);

  epr_rec_t rec_r;
  logic     busy_r;
  kind_t    kind_r;
  logic     is_end;
  logic     xfer;
  logic     done;

  assign is_end   = (kind_r == KIND_END);
  assign xfer     = busy_r && out_if.ready;
  assign done     = xfer && (is_end || (kind_r == KIND_GW_LO && !rec_r.has_end));
  assign ser_free = !busy_r || done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      kind_r <= KIND_RD;
    end else if (rec_load) begin
      busy_r <= 1'b1;
      kind_r <= rec.has_route ? KIND_RD : KIND_END;
    end else if (done) begin
      busy_r <= 1'b0;
    end else if (xfer) begin
      kind_r <= (kind_r == KIND_GW_LO) ? KIND_END : kind_t'(kind_r + 3'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rec_load) begin
      rec_r <= rec;
    end
  end

  always_comb begin
    case (kind_r)
      KIND_RD:     out_if.word_value = rec_r.rd;
      KIND_ESI_HI: out_if.word_value = {48'd0, rec_r.esi_hi};
      KIND_ESI_LO: out_if.word_value = rec_r.esi_lo;
      KIND_PFX_HI: out_if.word_value = rec_r.pfx[127:64];
      KIND_PFX_LO: out_if.word_value = rec_r.pfx[63:0];
      KIND_GW_HI:  out_if.word_value = rec_r.gw[127:64];
      KIND_GW_LO:  out_if.word_value = rec_r.gw[63:0];
      default:     out_if.word_value = '0;
    endcase
  end

  assign out_if.valid         = busy_r;
  assign out_if.word_kind     = kind_r;
  assign out_if.is_withdraw   = is_end ? 1'b0 : rec_r.withdraw;
  assign out_if.is_ipv6       = is_end ? 1'b0 : rec_r.ipv6;
  assign out_if.prefix_length = is_end ? 8'd0 : rec_r.plen;
  assign out_if.ethernet_tag  = is_end ? 32'd0 : rec_r.tag;
  assign out_if.mpls_label    = is_end ? 24'd0 : rec_r.label;
  assign out_if.last_word     = is_end || (kind_r == KIND_GW_LO);
  assign out_if.parse_status  = is_end ? rec_r.status : ST_OK;

endmodule

### rtl/evpn_prefix_route_parser_unit.sv
// Top level of the EVPN IP-prefix route parser
//
//  channel  | direction | transfer unit
//  ---------+-----------+-------------------------------------------
//  in_if    | in        | one NLRI byte with end and withdraw flags
//  out_if   | out       | one route or end word with route attributes
//  cfg_*    | in/out    | APB register access, peer_established
//
// A byte is taken each cycle unless stalled; one register stage precedes the parser.
// A route completion loads the word register and sends 7 or 8 words, one per cycle
// when out_if is ready; further bytes that yield no words keep flowing as it drains.
// A byte that yields words waits while an earlier run is still in the word register.
// Reset is synchronous; parser returns to the route type phase with no error.
`include "evpn_prefix_route_parser_unit_assert.svh"

module evpn_prefix_route_parser_unit
  import epr_pkg::*;
#(
  parameter logic [7:0] PREFIX_ROUTE_TYPE = PREFIX_ROUTE_TYPE_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  epr_in_if.sink            in_if,
  epr_out_if.source         out_if,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  logic     peer_est;
  logic     ser_free;
  logic     rec_load;
  epr_rec_t rec;

  epr_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .peer_est    (peer_est)
  );

  epr_parser #(
    .PREFIX_ROUTE_TYPE (PREFIX_ROUTE_TYPE)
  ) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .peer_est (peer_est),
    .in_if    (in_if),
    .ser_free (ser_free),
    .rec_load (rec_load),
    .rec      (rec)
  );

  epr_word_ser u_ser (
    .clk      (clk),
    .rst_n    (rst_n),
    .rec_load (rec_load),
    .rec      (rec),
    .ser_free (ser_free),
    .out_if   (out_if)
  );

  `EPR_ASSERT_NOW(a_end_is_last, out_if.valid && out_if.word_kind == KIND_END, out_if.last_word, "end word without last flag")

  `EPR_ASSERT_NEXT(a_run_advances, out_if.valid && out_if.ready && !out_if.last_word, out_if.valid && out_if.word_kind == $past(out_if.word_kind) + 3'd1, "route word run broken")

  `EPR_ASSERT_NOW(a_status_on_end, out_if.valid && out_if.word_kind != KIND_END, out_if.parse_status == ST_OK, "status on route word")

  `EPR_ASSERT_NEXT(a_load_when_free, rec_load && !ser_free, 1'b0, "word register overwritten")

endmodule
